// ===== rtl/core/dnsr_pkg.sv =====
package dnsr_pkg;

  localparam int SLOT_W      = 4;
  localparam int KIND_W      = 3;
  localparam int ADDR_W      = 32;
  localparam int MAX_RESULTS = 4;

  localparam logic [7:0] MAX_RETRIES_RESET = 8'd8;
  localparam logic [7:0] TTL_TICKS_RESET   = 8'd60;

  // Configuration register indexes.
  localparam logic [7:0] REG_MAX_RETRIES = 8'd0;
  localparam logic [7:0] REG_TTL_TICKS   = 8'd1;

  // Operation codes carried on the input tuser.
  localparam logic [1:0] OP_QUERY = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_RESP  = 2'd2;

  typedef enum logic [1:0] {
    ST_UNUSED = 2'd0,
    ST_NEW    = 2'd1,
    ST_ASKING = 2'd2,
    ST_DONE   = 2'd3
  } slot_st_t;

  typedef enum logic [KIND_W-1:0] {
    K_SEND     = 3'd0,
    K_ASSIGNED = 3'd1,
    K_RESOLVED = 3'd2,
    K_TIMEOUT  = 3'd3,
    K_REPLACED = 3'd4,
    K_ERROR    = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    U_AGE  = 2'd0,
    U_TAKE = 2'd1,
    U_TICK = 2'd2,
    U_RESP = 2'd3
  } unit_mode_t;

  typedef enum logic [2:0] {
    SEQ_IDLE   = 3'd0,
    SEQ_QSCAN  = 3'd1,
    SEQ_QTAKE  = 3'd2,
    SEQ_QASGN  = 3'd3,
    SEQ_TSCAN  = 3'd4,
    SEQ_RESP   = 3'd5,
    SEQ_FINISH = 3'd6
  } seq_t;

  typedef struct packed {
    slot_st_t   st;
    logic [7:0] timer;
    logic [7:0] count;
    logic [7:0] ttl;
    logic [7:0] stamp;
    logic       wants;
  } slot_rec_t;

  typedef struct packed {
    unit_mode_t mode;
    logic       found;
    logic       notify;
    logic       hdr_ok;
  } unit_ctl_t;

  typedef struct packed {
    logic  wr;
    logic  push;
    kind_t kind;
  } unit_res_t;

  typedef struct packed {
    logic              push;
    kind_t             kind;
    logic [SLOT_W-1:0] slot;
  } res_push_t;

endpackage

// ===== rtl/core/dns_resolver_slot_table.sv =====
// Resolver slot table.
// Input items arrive on the s_ stream: s_tuser carries the operation (query,
// tick, response) and s_tdata the request and response header fields.
// Each item yields zero to four results on the m_ stream; m_tlast marks the
// final result of an item. Registers max_retries and ttl_ticks are written on
// the cfg_ channel, which is always ready.
// Timing: one item is worked at a time by a single slot update unit that a
// sequencer steps over the table, one slot per cycle. A query scans for a
// free slot or else the oldest and then takes it, a tick visits every slot,
// and a response works only the slot its id names (none when its id is past
// the table). The results are then sent one per cycle while the receiver is
// ready, and s_tready rises again once the last result has been transferred.
// A stalled receiver holds the current result in place and keeps the block
// from taking further items. Reset marks every slot unused, clears all
// timers, stamps and notice flags, and loads the register defaults.
module dns_resolver_slot_table
  import dnsr_pkg::*;
#(
  parameter int TABLE_SLOTS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // notify[0], id[16:1], is_response[17], rcode[21:18], question_count[37:22],
  // answer_found[38], address[70:39], zero pad[71]
  input  logic [71:0] s_tdata,
  input  logic [1:0]  s_tuser,  // op[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,  // slot[3:0], resolved_address[35:4], zero pad
  output logic [2:0]  m_tuser,  // kind[2:0]
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_SLOTS - 1);

  seq_t              seq, seq_next;
  slot_rec_t         slots [TABLE_SLOTS];
  logic [7:0]        max_retries;
  logic [7:0]        ttl_ticks;
  logic [7:0]        next_stamp;
  logic [IW-1:0]     idx;
  logic [IW-1:0]     pick;
  logic [IW-1:0]     pick_sel;
  logic [7:0]        best;
  logic              found;
  logic              notify;
  logic              hdr_ok;
  logic [ADDR_W-1:0] addr;
  logic              in_xfer;
  logic              in_hdr_ok;
  logic              in_id_ok;
  logic              buf_busy;
  logic              close;
  logic              older;
  slot_rec_t         cur_rec;
  slot_rec_t         new_rec;
  unit_ctl_t         ctl;
  unit_res_t         ures;
  logic [7:0]        age;
  res_push_t         push;

  assign cfg_ready = 1'b1;
  assign in_xfer   = s_tvalid && s_tready;
  assign in_hdr_ok = s_tdata[17] && (s_tdata[21:18] == 4'd0)
                     && (s_tdata[37:22] == 16'd1) && s_tdata[38];
  assign in_id_ok  = (s_tdata[16:1] < 16'(TABLE_SLOTS));
  assign cur_rec   = slots[idx];
  assign older     = (age > best);
  assign pick_sel  = older ? idx : pick;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_retries <= MAX_RETRIES_RESET;
      ttl_ticks   <= TTL_TICKS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MAX_RETRIES: max_retries <= cfg_data;
        REG_TTL_TICKS:   ttl_ticks   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    seq_next = seq;
    unique case (seq)
      SEQ_IDLE: begin
        if (in_xfer) begin
          unique case (s_tuser)
            OP_QUERY: seq_next = SEQ_QSCAN;
            OP_TICK:  seq_next = SEQ_TSCAN;
            OP_RESP:  seq_next = in_id_ok ? SEQ_RESP : SEQ_FINISH;
            default:  seq_next = SEQ_FINISH;
          endcase
        end
      end
      SEQ_QSCAN: begin
        if (cur_rec.st == ST_UNUSED || idx == LAST_IDX) begin
          seq_next = SEQ_QTAKE;
        end
      end
      SEQ_QTAKE: seq_next = SEQ_QASGN;
      SEQ_QASGN: seq_next = SEQ_FINISH;
      SEQ_TSCAN: begin
        if (idx == LAST_IDX) begin
          seq_next = SEQ_FINISH;
        end
      end
      SEQ_RESP:   seq_next = SEQ_FINISH;
      SEQ_FINISH: seq_next = SEQ_IDLE;
      default:    seq_next = SEQ_IDLE;
    endcase
  end

  always_comb begin
    s_tready   = 1'b0;
    close      = 1'b0;
    ctl.mode   = U_AGE;
    ctl.found  = found;
    ctl.notify = notify;
    ctl.hdr_ok = hdr_ok;
    push.push  = ures.push;
    push.kind  = ures.kind;
    push.slot  = SLOT_W'(idx);
    unique case (seq)
      SEQ_IDLE:  s_tready = !buf_busy;
      SEQ_QSCAN: ctl.mode = U_AGE;
      SEQ_QTAKE: ctl.mode = U_TAKE;
      SEQ_QASGN: begin
        push.push = 1'b1;
        push.kind = K_ASSIGNED;
      end
      SEQ_TSCAN:  ctl.mode = U_TICK;
      SEQ_RESP:   ctl.mode = U_RESP;
      SEQ_FINISH: close = 1'b1;
      default: begin
      end
    endcase
    // Only the unit's own states may raise a push from it.
    if (seq == SEQ_IDLE || seq == SEQ_QSCAN || seq == SEQ_FINISH) begin
      push.push = 1'b0;
    end
  end

  dnsr_slot_unit u_unit (
    .ctl         (ctl),
    .rec_in      (cur_rec),
    .next_stamp  (next_stamp),
    .max_retries (max_retries),
    .ttl_ticks   (ttl_ticks),
    .rec_out     (new_rec),
    .res         (ures),
    .age         (age)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      seq        <= SEQ_IDLE;
      next_stamp <= 8'd0;
      idx        <= '0;
      pick       <= '0;
      best       <= 8'd0;
      found      <= 1'b0;
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        slots[i] <= '0;
      end
    end else begin
      seq <= seq_next;
      unique case (seq)
        SEQ_IDLE: begin
          if (in_xfer) begin
            idx   <= (s_tuser == OP_RESP) ? s_tdata[IW:1] : '0;
            pick  <= '0;
            best  <= 8'd0;
            found <= 1'b0;
          end
        end
        SEQ_QSCAN: begin
          if (cur_rec.st == ST_UNUSED) begin
            found <= 1'b1;
          end else begin
            if (older) begin
              best <= age;
              pick <= idx;
            end
            idx <= (idx == LAST_IDX) ? pick_sel : idx + IW'(1);
          end
        end
        SEQ_QTAKE: begin
          slots[idx] <= new_rec;
          next_stamp <= next_stamp + 8'd1;
        end
        SEQ_TSCAN: begin
          slots[idx] <= new_rec;
          idx        <= idx + IW'(1);
        end
        SEQ_RESP: begin
          if (ures.wr) begin
            slots[idx] <= new_rec;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      notify <= s_tdata[0];
      hdr_ok <= in_hdr_ok;
      addr   <= s_tdata[70:39];
    end
  end

  dnsr_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_addr (addr),
    .close     (close),
    .busy      (buf_busy),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !m_tvalid)
    else $error("input taken while results are pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("ready held across an accepted item");

  a_last_ends_burst: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast |=> !m_tvalid)
    else $error("result shown after the final transfer of an item");
`endif

endmodule

// ===== rtl/core/dnsr_slot_unit.sv =====
module dnsr_slot_unit
  import dnsr_pkg::*;
(
  input  unit_ctl_t  ctl,
  input  slot_rec_t  rec_in,
  input  logic [7:0] next_stamp,
  input  logic [7:0] max_retries,
  input  logic [7:0] ttl_ticks,
  output slot_rec_t  rec_out,
  output unit_res_t  res,
  output logic [7:0] age
);

  logic [7:0] timer_dec;
  logic [7:0] count_inc;
  logic [7:0] ttl_dec;

  assign timer_dec = rec_in.timer - 8'd1;
  assign count_inc = rec_in.count + 8'd1;
  assign ttl_dec   = rec_in.ttl - 8'd1;
  assign age       = next_stamp - rec_in.stamp;

  always_comb begin
    rec_out  = rec_in;
    res.wr   = 1'b0;
    res.push = 1'b0;
    res.kind = K_SEND;
    unique case (ctl.mode)
      U_AGE: begin
      end
      U_TAKE: begin
        res.wr        = 1'b1;
        res.push      = !ctl.found && rec_in.wants;
        res.kind      = K_REPLACED;
        rec_out.st    = ST_NEW;
        rec_out.stamp = next_stamp;
        rec_out.wants = ctl.notify;
      end
      U_TICK: begin
        res.wr = 1'b1;
        unique case (rec_in.st)
          ST_NEW: begin
            rec_out.st    = ST_ASKING;
            rec_out.timer = 8'd1;
            rec_out.count = 8'd0;
            res.push      = 1'b1;
          end
          ST_ASKING: begin
            rec_out.timer = timer_dec;
            if (timer_dec == 8'd0) begin
              rec_out.count = count_inc;
              if (count_inc >= max_retries) begin
                res.push      = rec_in.wants;
                res.kind      = K_TIMEOUT;
                rec_out.st    = ST_UNUSED;
                rec_out.wants = 1'b0;
              end else begin
                rec_out.timer = count_inc;
                res.push      = 1'b1;
              end
            end
          end
          ST_DONE: begin
            rec_out.ttl = ttl_dec;
            if (ttl_dec == 8'd0) begin
              rec_out.st    = ST_UNUSED;
              rec_out.wants = 1'b0;
            end
          end
          default: begin
          end
        endcase
      end
      U_RESP: begin
        if (rec_in.st == ST_ASKING) begin
          res.wr      = 1'b1;
          rec_out.st  = ST_DONE;
          rec_out.ttl = ttl_ticks;
          res.push    = rec_in.wants;
          if (ctl.hdr_ok) begin
            res.kind = K_RESOLVED;
          end else begin
            res.kind      = K_ERROR;
            rec_out.st    = ST_UNUSED;
            rec_out.wants = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/core/dnsr_out_buf.sv =====
module dnsr_out_buf
  import dnsr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  res_push_t         push,
  input  logic [ADDR_W-1:0] push_addr,
  input  logic              close,
  output logic              busy,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [39:0]       m_tdata,  // slot[3:0], resolved_address[35:4], zero pad
  output logic [2:0]        m_tuser,  // kind[2:0]
  output logic              m_tlast
);

  localparam int CW = $clog2(MAX_RESULTS + 1);
  localparam int RW = $clog2(MAX_RESULTS);

  kind_t             kind_mem [MAX_RESULTS];
  logic [SLOT_W-1:0] slot_mem [MAX_RESULTS];
  logic [ADDR_W-1:0] addr;
  logic [CW-1:0]     cnt;
  logic [RW-1:0]     rd;
  logic              draining;
  logic              is_last;
  kind_t             cur_kind;

  assign is_last  = (CW'(rd) == cnt - CW'(1));
  assign cur_kind = kind_mem[rd];
  assign busy     = draining;
  assign m_tvalid = draining;
  assign m_tlast  = is_last;
  assign m_tuser  = cur_kind;
  assign m_tdata  = {4'd0, (cur_kind == K_RESOLVED) ? addr : '0, slot_mem[rd]};

  // Results beyond the fourth of one item are dropped.
  always_ff @(posedge clk) begin
    if (push.push && !draining && cnt < CW'(MAX_RESULTS)) begin
      kind_mem[cnt[RW-1:0]] <= push.kind;
      slot_mem[cnt[RW-1:0]] <= push.slot;
      addr                  <= push_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      rd       <= '0;
      draining <= 1'b0;
    end else if (draining) begin
      if (m_tready) begin
        if (is_last) begin
          draining <= 1'b0;
          cnt      <= '0;
          rd       <= '0;
        end else begin
          rd <= rd + RW'(1);
        end
      end
    end else begin
      if (push.push && cnt < CW'(MAX_RESULTS)) begin
        cnt <= cnt + CW'(1);
      end
      if (close && cnt != '0) begin
        draining <= 1'b1;
      end
    end
  end

endmodule
